// ===== design/cltok_pkg.sv =====
// cltok_pkg: shared types, codes and byte classes of the command line tokenizer
`default_nettype none
package cltok_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_ASCII_MAX = 8'd127;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WORD  = 3'd1,
    MODE_QUOTE = 3'd2,
    MODE_AFTER = 3'd3,
    MODE_ERROR = 3'd4
  } scan_mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_UNTERM = 2'd2,
    ST_SYNTAX = 2'd3
  } line_status_t;

  typedef struct packed {
    scan_mode_t  mode;
    logic        quote_is_double;
    logic [7:0]  token_count;
  } scan_state_t;

  typedef struct packed {
    logic [7:0]   byte_out;
    logic         in_token;
    logic         token_done;
    logic [7:0]   token_index;
    logic         line_end;
    line_status_t status;
  } step_result_t;

  localparam scan_state_t SCAN_RESET = '{mode: MODE_IDLE, quote_is_double: 1'b0,
                                         token_count: 8'd0};

  // letters, digits, - . _ * and the upper half of the byte range
  function automatic logic is_allowed(input logic [7:0] c);
    logic ok;
    ok = 1'b0;
    if (c >= 8'h61 && c <= 8'h7A) ok = 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) ok = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) ok = 1'b1;
    if (c == CH_DASH || c == CH_DOT || c == CH_USCORE || c == CH_STAR) ok = 1'b1;
    if (c > CH_ASCII_MAX) ok = 1'b1;
    return ok;
  endfunction

endpackage
`default_nettype wire

// ===== design/cltok_step.sv =====
// cltok_step: per-byte scanner update and result fields
`default_nettype none
module cltok_step (
  input  wire logic [7:0]               ch,
  input  wire cltok_pkg::scan_state_t   st,
  output cltok_pkg::scan_state_t        st_nxt,
  output cltok_pkg::step_result_t       res
);

  logic [7:0] cnt_inc;
  logic       allowed;
  logic [7:0] closer;

  assign cnt_inc = (st.token_count == cltok_pkg::COUNT_MAX) ? st.token_count
                                                           : st.token_count + 8'd1;
  assign allowed = cltok_pkg::is_allowed(ch);
  assign closer  = st.quote_is_double ? cltok_pkg::CH_DQUOTE : cltok_pkg::CH_SQUOTE;

  always_comb begin
    st_nxt          = st;
    res.byte_out    = ch;
    res.in_token    = 1'b0;
    res.token_done  = 1'b0;
    res.token_index = 8'd0;
    res.line_end    = 1'b0;
    res.status      = cltok_pkg::ST_OK;

    if (ch == cltok_pkg::CH_NUL) begin
      res.line_end = 1'b1;
      if (st.mode == cltok_pkg::MODE_WORD) begin
        res.token_done  = 1'b1;
        res.token_index = st.token_count;
      end
      if (st.mode == cltok_pkg::MODE_ERROR) begin
        res.status = cltok_pkg::ST_SYNTAX;
      end else if (st.mode == cltok_pkg::MODE_QUOTE) begin
        res.status = cltok_pkg::ST_UNTERM;
      end else if (st.mode != cltok_pkg::MODE_WORD && st.token_count == 8'd0) begin
        res.status = cltok_pkg::ST_EMPTY;
      end
      st_nxt = cltok_pkg::SCAN_RESET;
    end else begin
      unique case (st.mode)
        cltok_pkg::MODE_WORD: begin
          if (allowed) begin
            res.in_token    = 1'b1;
            res.token_index = st.token_count;
          end else begin
            res.token_done     = 1'b1;
            res.token_index    = st.token_count;
            st_nxt.token_count = cnt_inc;
            st_nxt.mode = (ch == cltok_pkg::CH_SPACE) ? cltok_pkg::MODE_IDLE
                                                      : cltok_pkg::MODE_ERROR;
          end
        end
        cltok_pkg::MODE_QUOTE: begin
          if (ch == closer) begin
            res.token_done     = 1'b1;
            res.token_index    = st.token_count;
            st_nxt.token_count = cnt_inc;
            st_nxt.mode        = cltok_pkg::MODE_AFTER;
          end else begin
            res.in_token    = 1'b1;
            res.token_index = st.token_count;
          end
        end
        cltok_pkg::MODE_AFTER: begin
          st_nxt.mode = (ch == cltok_pkg::CH_SPACE) ? cltok_pkg::MODE_IDLE
                                                    : cltok_pkg::MODE_ERROR;
        end
        cltok_pkg::MODE_ERROR: begin
          st_nxt.mode = cltok_pkg::MODE_ERROR;
        end
        default: begin
          // idle between words, also any unused mode code
          priority if (ch == cltok_pkg::CH_SPACE) begin
            st_nxt.mode = cltok_pkg::MODE_IDLE;
          end else if (allowed) begin
            res.in_token    = 1'b1;
            res.token_index = st.token_count;
            st_nxt.mode     = cltok_pkg::MODE_WORD;
          end else if (ch == cltok_pkg::CH_DQUOTE || ch == cltok_pkg::CH_SQUOTE) begin
            res.token_index        = st.token_count;
            st_nxt.quote_is_double = (ch == cltok_pkg::CH_DQUOTE);
            st_nxt.mode            = cltok_pkg::MODE_QUOTE;
          end else begin
            st_nxt.mode = cltok_pkg::MODE_ERROR;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/command_line_tokenizer_unit.sv =====
// command_line_tokenizer_unit: top level of the command line tokenizer
//
// splits a command line, one byte per input transaction, into shell words:
// runs of letters, digits, - . _ * and bytes 128-255, or text between a
// matching pair of single or double quotes. only space separates words; a
// zero byte ends the line, reports ok / empty / unterminated quote / syntax
// error on out_status and returns the scanner to its reset state. every
// input transaction gives exactly one result transaction. the block takes
// one byte per clock while out_ready stays high: the byte is registered,
// the scanner state update and result fields are computed combinationally,
// and the result lands in an output register. in_ready falls only when
// both the input register and the output register are full and the output
// is stalled.
`default_nettype none
module command_line_tokenizer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_ch,
  // result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte_out,
  output logic            out_in_token,
  output logic            out_token_done,
  output logic [7:0]      out_token_index,
  output logic            out_line_end,
  output logic [1:0]      out_status
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;

  // scanner state
  cltok_pkg::scan_state_t  scan_r;
  cltok_pkg::scan_state_t  scan_nxt;

  // output register
  logic                    out_valid_r;
  cltok_pkg::step_result_t res_r;
  cltok_pkg::step_result_t res_nxt;

  logic out_free;
  logic s1_adv;

  // output register can take a new result this cycle
  assign out_free = !out_valid_r || out_ready;
  // registered byte moves through the scanner into the output register
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  cltok_step u_step (
    .ch     (s1_ch_r),
    .st     (scan_r),
    .st_nxt (scan_nxt),
    .res    (res_nxt)
  );

  // input register: payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch_r <= in_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // scanner state advances once per byte, in order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= cltok_pkg::SCAN_RESET;
    end else if (s1_adv) begin
      scan_r <= scan_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_out    = res_r.byte_out;
  assign out_in_token    = res_r.in_token;
  assign out_token_done  = res_r.token_done;
  assign out_token_index = res_r.token_index;
  assign out_line_end    = res_r.line_end;
  assign out_status      = res_r.status;

endmodule
`default_nettype wire

// ===== design/cltok_checker.sv =====
// cltok_checker: port-level assertions for the command line tokenizer
`default_nettype none
module cltok_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte_out,
  input wire logic       out_in_token,
  input wire logic       out_token_done,
  input wire logic [7:0] out_token_index,
  input wire logic       out_line_end,
  input wire logic [1:0] out_status
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_out)
      && $stable(out_status) && $stable(out_token_index))
    else $error("result changed while stalled");

  // line end flags exactly the zero byte
  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_end == (out_byte_out == 8'd0))
    else $error("line_end does not match zero byte");

  // status only reported at line end
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_end |-> out_status == cltok_pkg::ST_OK)
    else $error("status outside line end");

  // a byte is never both word text and the end of a word
  a_text_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_in_token && out_token_done))
    else $error("in_token and token_done together");

  // no word ends with an unterminated quote or an empty line
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_end && out_token_done |->
      out_status == cltok_pkg::ST_OK || out_status == cltok_pkg::ST_SYNTAX)
    else $error("token_done at line end with wrong status");

endmodule

bind command_line_tokenizer_unit cltok_checker u_cltok_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte_out    (out_byte_out),
  .out_in_token    (out_in_token),
  .out_token_done  (out_token_done),
  .out_token_index (out_token_index),
  .out_line_end    (out_line_end),
  .out_status      (out_status)
);
`default_nettype wire

// ===== tb/command_line_tokenizer_unit_tb.sv =====
`timescale 1ns / 100ps
// command_line_tokenizer_unit_tb: self-checking testbench for the command line tokenizer
module command_line_tokenizer_unit_tb;

  // run shape
  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run of ~1300 bytes
  localparam int RANDOM_BYTES = 1150;    // random lines stop once this many bytes went in
  localparam int STEADY_BYTES = 150;     // closing stretch with both sides always ready
  localparam int SAT_WORDS    = 262;     // enough words to push the index past its ceiling
  localparam int MAX_REPORTS  = 40;      // keep the log short on a badly broken build
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef logic [7:0] line_q_t[$];

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_ch = cltok_pkg::CH_NUL;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte_out;
  logic       out_in_token;
  logic       out_token_done;
  logic [7:0] out_token_index;
  logic       out_line_end;
  logic [1:0] out_status;

  // tokenizer state as the testbench tracks it
  cltok_pkg::scan_mode_t mdl_mode = cltok_pkg::MODE_IDLE;
  logic       mdl_dquote = 1'b0;
  logic [7:0] mdl_words = 8'd0;
  logic       mdl_err = 1'b0;

  // results owed by the block, oldest first
  cltok_pkg::step_result_t step_due_q[$];

  int bytes_sent = 0;
  int lines_sent = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int stall_left = 0;
  int status_seen[4] = '{default: 0};
  bit idle_on = 1'b1;

  command_line_tokenizer_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_out   (out_byte_out),
    .out_in_token   (out_in_token),
    .out_token_done (out_token_done),
    .out_token_index(out_token_index),
    .out_line_end   (out_line_end),
    .out_status     (out_status)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // tokenizer prediction
  // ---------------------------------------------------------------------------

  // bytes that may form a bare word
  function automatic bit word_byte_ok(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) return 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) return 1'b1;
    if (c >= 8'h30 && c <= 8'h39) return 1'b1;
    if (c == cltok_pkg::CH_DASH || c == cltok_pkg::CH_DOT ||
        c == cltok_pkg::CH_USCORE || c == cltok_pkg::CH_STAR) return 1'b1;
    return c > cltok_pkg::CH_ASCII_MAX;
  endfunction

  // index of the word being closed; the count sticks at its ceiling
  function automatic logic [7:0] close_word();
    logic [7:0] idx;
    idx = mdl_words;
    if (mdl_words != cltok_pkg::COUNT_MAX) mdl_words = mdl_words + 8'd1;
    return idx;
  endfunction

  // one byte through the scanner: returns the result it must produce
  function automatic cltok_pkg::step_result_t tokenize_byte(input logic [7:0] c);
    cltok_pkg::step_result_t r;
    logic [7:0] closer;
    r = '0;
    r.byte_out = c;
    if (c == cltok_pkg::CH_NUL) begin
      // end of line: a bare word still open is finished here
      r.line_end = 1'b1;
      if (mdl_mode == cltok_pkg::MODE_WORD) begin
        r.token_done = 1'b1;
        r.token_index = close_word();
      end
      // syntax error wins over an open quote, which wins over empty
      if (mdl_err || mdl_mode == cltok_pkg::MODE_ERROR) r.status = cltok_pkg::ST_SYNTAX;
      else if (mdl_mode == cltok_pkg::MODE_QUOTE) r.status = cltok_pkg::ST_UNTERM;
      else if (mdl_words == 8'd0) r.status = cltok_pkg::ST_EMPTY;
      else r.status = cltok_pkg::ST_OK;
      mdl_mode = cltok_pkg::MODE_IDLE;
      mdl_dquote = 1'b0;
      mdl_words = 8'd0;
      mdl_err = 1'b0;
    end else begin
      case (mdl_mode)
        cltok_pkg::MODE_WORD: begin
          if (word_byte_ok(c)) begin
            r.in_token = 1'b1;
            r.token_index = mdl_words;
          end else begin
            // the word ends on this byte even when the byte itself is bad
            r.token_done = 1'b1;
            r.token_index = close_word();
            if (c == cltok_pkg::CH_SPACE) begin
              mdl_mode = cltok_pkg::MODE_IDLE;
            end else begin
              mdl_mode = cltok_pkg::MODE_ERROR;
              mdl_err = 1'b1;
            end
          end
        end
        cltok_pkg::MODE_QUOTE: begin
          closer = mdl_dquote ? cltok_pkg::CH_DQUOTE : cltok_pkg::CH_SQUOTE;
          if (c == closer) begin
            r.token_done = 1'b1;
            r.token_index = close_word();
            mdl_mode = cltok_pkg::MODE_AFTER;
          end else begin
            r.in_token = 1'b1;
            r.token_index = mdl_words;
          end
        end
        cltok_pkg::MODE_AFTER: begin
          // only a space may follow a closing quote
          if (c == cltok_pkg::CH_SPACE) begin
            mdl_mode = cltok_pkg::MODE_IDLE;
          end else begin
            mdl_mode = cltok_pkg::MODE_ERROR;
            mdl_err = 1'b1;
          end
        end
        cltok_pkg::MODE_ERROR: begin
          // latched: every byte until the zero byte is inert
        end
        default: begin
          if (c == cltok_pkg::CH_SPACE) begin
            mdl_mode = cltok_pkg::MODE_IDLE;
          end else if (word_byte_ok(c)) begin
            r.in_token = 1'b1;
            r.token_index = mdl_words;
            mdl_mode = cltok_pkg::MODE_WORD;
          end else if (c == cltok_pkg::CH_DQUOTE || c == cltok_pkg::CH_SQUOTE) begin
            // opening quote carries the index but is not text
            mdl_dquote = (c == cltok_pkg::CH_DQUOTE);
            r.token_index = mdl_words;
            mdl_mode = cltok_pkg::MODE_QUOTE;
          end else begin
            mdl_mode = cltok_pkg::MODE_ERROR;
            mdl_err = 1'b1;
          end
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // random line content
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_word_byte();
    case ($urandom_range(0, 4))
      0: return 8'h61 + 8'($urandom_range(0, 25));
      1: return 8'h41 + 8'($urandom_range(0, 25));
      2: return 8'h30 + 8'($urandom_range(0, 9));
      3: begin
        case ($urandom_range(0, 3))
          0: return cltok_pkg::CH_DASH;
          1: return cltok_pkg::CH_DOT;
          2: return cltok_pkg::CH_USCORE;
          default: return cltok_pkg::CH_STAR;
        endcase
      end
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  // anything but the zero byte and the matching closer, mostly printable
  function automatic logic [7:0] rand_quoted_byte(input logic [7:0] closer);
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(32, 126));
      else b = 8'($urandom_range(1, 255));
    end while (b == closer);
    return b;
  endfunction

  // a byte that can never start or continue a bare word (quotes included)
  function automatic logic [7:0] rand_bad_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 127));
    while (word_byte_ok(b) || b == cltok_pkg::CH_SPACE);
    return b;
  endfunction

  // mostly well-formed line with random words; some lines get damaged
  function automatic line_q_t make_line();
    line_q_t q;
    int ntok;
    logic [7:0] closer;
    q = {};
    ntok = $urandom_range(0, 6);
    repeat ($urandom_range(0, 2)) q.insert(q.size(), cltok_pkg::CH_SPACE);
    for (int t = 0; t < ntok; t++) begin
      if (t != 0) repeat ($urandom_range(1, 2)) q.insert(q.size(), cltok_pkg::CH_SPACE);
      if ($urandom_range(0, 2) == 0) begin
        closer = $urandom_range(0, 1) ? cltok_pkg::CH_DQUOTE : cltok_pkg::CH_SQUOTE;
        q.insert(q.size(), closer);
        repeat ($urandom_range(0, 5)) q.insert(q.size(), rand_quoted_byte(closer));
        q.insert(q.size(), closer);
      end else begin
        repeat ($urandom_range(1, 6)) q.insert(q.size(), rand_word_byte());
      end
    end
    repeat ($urandom_range(0, 2)) q.insert(q.size(), cltok_pkg::CH_SPACE);
    case ($urandom_range(0, 9))
      // stray bad byte somewhere
      0: q.insert($urandom_range(0, q.size()), rand_bad_byte());
      // quote left open at the end
      1: begin
        closer = $urandom_range(0, 1) ? cltok_pkg::CH_DQUOTE : cltok_pkg::CH_SQUOTE;
        q.insert(q.size(), closer);
        repeat ($urandom_range(0, 3)) q.insert(q.size(), rand_quoted_byte(closer));
      end
      // stray quote: may open early, close early or follow a word
      2: begin
        closer = $urandom_range(0, 1) ? cltok_pkg::CH_DQUOTE : cltok_pkg::CH_SQUOTE;
        q.insert($urandom_range(0, q.size()), closer);
      end
      default: begin
      end
    endcase
    q.insert(q.size(), cltok_pkg::CH_NUL);
    return q;
  endfunction

  // raw noise, zero bytes included, so lines break anywhere
  function automatic line_q_t make_noise();
    line_q_t q;
    q = {};
    repeat ($urandom_range(1, 8)) q.insert(q.size(), 8'($urandom_range(0, 255)));
    q.insert(q.size(), cltok_pkg::CH_NUL);
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one transaction per byte, driven on the falling edge
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b);
    cltok_pkg::step_result_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted on this edge: the result it owes goes to the back of the queue
    r = tokenize_byte(b);
    step_due_q.insert(step_due_q.size(), r);
    bytes_sent++;
    if (r.line_end) begin
      lines_sent++;
      status_seen[int'(r.status)]++;
    end
    @(negedge clk);
  endtask

  task automatic send_line(input line_q_t line);
    foreach (line[i]) send_byte(line[i]);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // short hand-picked lines: each status and each corner of the scanner
  task automatic test_directed_lines();
    line_q_t q;
    // nothing but the terminator: empty
    q = {cltok_pkg::CH_NUL};
    send_line(q);
    // tab where a word could start, then a letter that the latch swallows
    q = {CH_TAB, 8'h61, cltok_pkg::CH_NUL};
    send_line(q);
    // high bytes as a bare word, empty double quotes, single-quoted text
    // holding a space and a double quote: ok
    q = {8'h80, 8'hFF, cltok_pkg::CH_SPACE, cltok_pkg::CH_DQUOTE, cltok_pkg::CH_DQUOTE,
         cltok_pkg::CH_SPACE, cltok_pkg::CH_SQUOTE, cltok_pkg::CH_SPACE,
         cltok_pkg::CH_DQUOTE, cltok_pkg::CH_SQUOTE, cltok_pkg::CH_NUL};
    send_line(q);
    // quote right after a bare word: word finishes and the error latches
    q = {8'h7A, cltok_pkg::CH_SQUOTE, cltok_pkg::CH_NUL};
    send_line(q);
    // quote never closed, with a disallowed byte inside it
    q = {cltok_pkg::CH_SQUOTE, 8'h7F, cltok_pkg::CH_NUL};
    send_line(q);
    // quote opened straight after a closed quote
    q = {cltok_pkg::CH_DQUOTE, cltok_pkg::CH_DQUOTE, cltok_pkg::CH_SQUOTE,
         cltok_pkg::CH_NUL};
    send_line(q);
  endtask

  // one long line whose word index runs into its ceiling
  task automatic test_token_saturation();
    line_q_t q;
    q = {};
    for (int w = 0; w < SAT_WORDS; w++) begin
      if (w % 3 == 2) begin
        q.insert(q.size(), cltok_pkg::CH_SQUOTE);
        q.insert(q.size(), cltok_pkg::CH_SQUOTE);
      end else begin
        q.insert(q.size(), rand_word_byte());
      end
      q.insert(q.size(), cltok_pkg::CH_SPACE);
    end
    // last word is closed by the terminator at the saturated index
    q.insert(q.size(), rand_word_byte());
    q.insert(q.size(), cltok_pkg::CH_NUL);
    send_line(q);
  endtask

  task automatic test_random_lines();
    line_q_t q;
    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) q = make_noise();
      else q = make_line();
      send_line(q);
    end
  endtask

  // back-to-back transactions with the result side always ready
  task automatic test_full_rate();
    line_q_t q;
    idle_on = 1'b0;
    while (bytes_sent < RANDOM_BYTES + STEADY_BYTES) begin
      q = make_line();
      send_line(q);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, checked on the rising edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: out_%s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    cltok_pkg::step_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (step_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result transaction with none pending, expected none, actual byte %0d",
                   $time, out_byte_out);
      end else begin
        want = step_due_q.pop_front();
        check_field("byte_out", want.byte_out, out_byte_out);
        check_field("in_token", want.in_token, out_in_token);
        check_field("token_done", want.token_done, out_token_done);
        check_field("token_index", want.token_index, out_token_index);
        check_field("line_end", want.line_end, out_line_end);
        check_field("status", want.status, out_status);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("command_line_tokenizer_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    // reset held, then released on a falling edge
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_lines();
    test_token_saturation();
    test_random_lines();
    test_full_rate();
    in_valid <= 1'b0;

    // drain: every owed result, then wait to catch anything spurious
    while (step_due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d bytes in %0d lines: %0d ok, %0d empty, %0d open quote, %0d syntax error",
             bytes_sent, lines_sent, status_seen[cltok_pkg::ST_OK],
             status_seen[cltok_pkg::ST_EMPTY], status_seen[cltok_pkg::ST_UNTERM],
             status_seen[cltok_pkg::ST_SYNTAX]);
    $display("bare and quoted words, stray bytes, index ceiling, stalls on both sides");
    if (mismatches == 0) begin
      $display("command_line_tokenizer_unit verification clean");
    end else begin
      $display("command_line_tokenizer_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/cltok_pkg.sv
design/cltok_step.sv
design/command_line_tokenizer_unit.sv
design/cltok_checker.sv
tb/command_line_tokenizer_unit_tb.sv
